FILE: src/sef_pkg.sv
`default_nettype none

package sef_pkg;

  localparam int unsigned CH_W       = 8;
  localparam int unsigned NUM_CH     = 3;
  localparam int unsigned IMG_W_W    = 11;
  localparam int unsigned IMG_H_W    = 12;
  localparam int unsigned CFG_IDX_W  = 1;
  localparam int unsigned CFG_DATA_W = 16;

  localparam int unsigned RESET_WIDTH  = 640;
  localparam int unsigned RESET_HEIGHT = 480;

  // result queue behind the window pipeline
  localparam int unsigned FIFO_DEPTH = 4;
  localparam int unsigned FIFO_PTR_W = 2;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_IMAGE_WIDTH  = 1'b0,
    CFG_IMAGE_HEIGHT = 1'b1
  } cfg_reg_e;

  // channel 2 is red, 1 green, 0 blue
  typedef logic [NUM_CH-1:0][CH_W-1:0] pixel_t;

  // one column of the 3x3 window
  typedef struct packed {
    pixel_t top;
    pixel_t mid;
    pixel_t bot;
  } column_t;

  typedef struct packed {
    pixel_t px;
    logic   last;
  } result_t;

endpackage

`default_nettype wire

FILE: src/sef_if.sv
`default_nettype none

interface sef_pix_in_if;
  import sef_pkg::*;
  logic            valid;
  logic            ready;
  logic [CH_W-1:0] red_in;
  logic [CH_W-1:0] green_in;
  logic [CH_W-1:0] blue_in;
  logic            flush;

  modport source (output valid, red_in, green_in, blue_in, flush, input ready);
  modport sink   (input valid, red_in, green_in, blue_in, flush, output ready);
endinterface

interface sef_pix_out_if;
  import sef_pkg::*;
  logic            valid;
  logic            ready;
  logic [CH_W-1:0] red_out;
  logic [CH_W-1:0] green_out;
  logic [CH_W-1:0] blue_out;
  logic            frame_last;

  modport source (output valid, red_out, green_out, blue_out, frame_last, input ready);
  modport sink   (input valid, red_out, green_out, blue_out, frame_last, output ready);
endinterface

interface sef_cfg_if;
  import sef_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

FILE: src/sef_ram.sv
`default_nettype none

module sef_ram #(
  parameter int unsigned WIDTH = 24,
  parameter int unsigned DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // read-first: same-address read returns the old word
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

FILE: src/sef_col_cell.sv
`default_nettype none

module sef_col_cell (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             en_i,
  input  sef_pkg::column_t col_i,
  output sef_pkg::column_t col_o
);
  import sef_pkg::*;

  column_t col_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
    end else if (en_i) begin
      col_q <= col_i;
    end
  end

  assign col_o = col_q;

endmodule

`default_nettype wire

FILE: src/sef_sobel_ch.sv
`default_nettype none

module sef_sobel_ch (
  input  logic [2:0][sef_pkg::CH_W-1:0] t_i,   // top row, left to right
  input  logic [sef_pkg::CH_W-1:0]      m0_i,  // middle row, left
  input  logic [sef_pkg::CH_W-1:0]      m2_i,  // middle row, right
  input  logic [2:0][sef_pkg::CH_W-1:0] b_i,   // bottom row, left to right
  output logic [sef_pkg::CH_W-1:0]      res_o
);
  import sef_pkg::*;

  localparam int unsigned SW = CH_W + 2;  // weighted 1,2,1 sum

  logic [SW-1:0]   gy_pos, gy_neg, gx_pos, gx_neg;
  logic [SW:0]     gy, gx;
  logic [CH_W-1:0] gy_c, gx_c;
  logic [CH_W:0]   sum;

  function automatic logic [CH_W-1:0] clamp_byte(input logic [SW:0] v);
    logic [CH_W-1:0] r;
    if (v[SW]) begin
      r = '0;
    end else if (v[SW-1:CH_W] != '0) begin
      r = '1;
    end else begin
      r = v[CH_W-1:0];
    end
    return r;
  endfunction

  always_comb begin
    gy_pos = SW'(t_i[0]) + {1'b0, t_i[1], 1'b0} + SW'(t_i[2]);
    gy_neg = SW'(b_i[0]) + {1'b0, b_i[1], 1'b0} + SW'(b_i[2]);
    gx_pos = SW'(t_i[0]) + {1'b0, m0_i, 1'b0} + SW'(b_i[0]);
    gx_neg = SW'(t_i[2]) + {1'b0, m2_i, 1'b0} + SW'(b_i[2]);
    gy     = {1'b0, gy_pos} - {1'b0, gy_neg};
    gx     = {1'b0, gx_pos} - {1'b0, gx_neg};
    gy_c   = clamp_byte(gy);
    gx_c   = clamp_byte(gx);
    sum    = {1'b0, gy_c} + {1'b0, gx_c};
    res_o  = sum[CH_W:1];
  end

endmodule

`default_nettype wire

FILE: src/sobel_edge_filter_3x3.sv
// Sobel edge filter, 3x3, on an RGB pixel stream in raster order.
// pix_i : input transactions; one pixel (red_in/green_in/blue_in) or, with
//         flush set, a drain request carrying no pixel.
// pix_o : result transactions; filtered or passed-through pixel, frame_last
//         set on the bottom-right pixel of the frame.
// cfg_i : register writes (index 0 image_width, 1 image_height), always
//         ready; a write restarts the stream positions. Write only when idle.
// Throughput: one transaction per cycle on each side while pix_o.ready is held high.
// Lag: output is width+1 pixels behind input in the stream; a transaction
//   that yields a result passes the line RAM read and window shift, then
//   the Sobel stage into the result queue, before it shows on pix_o.
//   Flush transactions drain the last width+1 pixels at the frame end.
// Window: a chain of three column cells that shift on every pixel; two line
//   RAMs of MAX_WIDTH entries feed the upper and middle rows.
// Stall: a 4-entry result queue sits in front of pix_o; pix_i.ready drops
//   only when the queue plus results still in flight take all four entries.
// Reset: positions, queue and window clear at once, width 640, height 480;
//   line RAMs are not cleared and need no clearing pass.
`default_nettype none

module sobel_edge_filter_3x3 #(
  parameter int unsigned MAX_WIDTH = 1024
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  sef_pix_in_if.sink    pix_i,
  sef_pix_out_if.source pix_o,
  sef_cfg_if.sink       cfg_i
);
  import sef_pkg::*;

  localparam int unsigned AW = $clog2(MAX_WIDTH);       // line RAM address
  localparam int unsigned WW = $clog2(MAX_WIDTH + 1);   // effective width
  localparam int unsigned PW = $clog2(MAX_WIDTH + 2);   // pending count
  localparam int unsigned CW = ((WW > IMG_W_W) ? WW : IMG_W_W) + 1;
  localparam int unsigned RST_W_EFF = (RESET_WIDTH > MAX_WIDTH) ? MAX_WIDTH
                                                                : RESET_WIDTH;
  localparam int unsigned PIX_W = NUM_CH * CH_W;

  // ---------------- configuration ----------------
  logic [AW-1:0]      wm1_q, wm1_d;     // effective width - 1
  logic [IMG_H_W-1:0] hm1_q, hm1_d;     // effective height - 1
  logic               cfg_acc;
  logic [CW-1:0]      cfg_w;
  logic [IMG_H_W-1:0] cfg_h;

  assign cfg_i.ready = 1'b1;
  assign cfg_acc     = cfg_i.valid;
  assign cfg_w       = CW'(cfg_i.data[IMG_W_W-1:0]);
  assign cfg_h       = cfg_i.data[IMG_H_W-1:0];

  always_comb begin
    wm1_d = wm1_q;
    hm1_d = hm1_q;
    if (cfg_acc) begin
      unique case (cfg_reg_e'(cfg_i.index))
        CFG_IMAGE_WIDTH: begin
          // zero acts as one, anything above MAX_WIDTH as MAX_WIDTH
          if (cfg_w == '0) begin
            wm1_d = '0;
          end else if (cfg_w > CW'(MAX_WIDTH)) begin
            wm1_d = AW'(MAX_WIDTH - 1);
          end else begin
            wm1_d = AW'(cfg_w - CW'(1));
          end
        end
        CFG_IMAGE_HEIGHT: begin
          hm1_d = (cfg_h == '0) ? '0 : cfg_h - IMG_H_W'(1);
        end
        default: begin
          wm1_d = wm1_q;
        end
      endcase
    end
  end

  // ---------------- stage 0: positions and RAM read address ----------------
  logic [AW-1:0]      col_q, col_d;     // column of the next input pixel
  logic [PW-1:0]      pend_q, pend_d;   // pixels taken but not yet output
  logic [AW-1:0]      ocol_q, ocol_d;   // output position
  logic [IMG_H_W-1:0] orow_q, orow_d;

  logic          in_acc, is_flush, emit0, border0, last0, sel_mid0;
  logic [PW-1:0] wp, col_p;
  logic [AW-1:0] raddr_up, raddr_mid;
  pixel_t        px_in;

  assign in_acc   = pix_i.valid && pix_i.ready;
  assign is_flush = pix_i.flush;
  assign px_in    = {pix_i.red_in, pix_i.green_in, pix_i.blue_in};
  assign wp       = PW'(wm1_q) + PW'(1);
  assign col_p    = PW'(col_q);

  // a pixel yields a result once width+1 pixels are pending; a flush drains one
  assign emit0    = is_flush ? (pend_q != '0) : (pend_q > wp);
  assign sel_mid0 = (pend_q <= wp);
  assign border0  = (orow_q == '0) || (orow_q == hm1_q) ||
                    (ocol_q == '0) || (ocol_q == wm1_q);
  assign last0    = (orow_q == hm1_q) && (ocol_q == wm1_q);

  always_comb begin
    if (is_flush) begin
      // middle store holds the last width pixels, upper the one before them
      if (col_p >= pend_q) begin
        raddr_mid = AW'(col_p - pend_q);
      end else begin
        raddr_mid = AW'(col_p + wp - pend_q);
      end
      raddr_up = (col_q == '0) ? wm1_q : col_q - AW'(1);
    end else begin
      raddr_mid = col_q;
      raddr_up  = col_q;
    end
  end

  always_comb begin
    col_d  = col_q;
    pend_d = pend_q;
    ocol_d = ocol_q;
    orow_d = orow_q;
    if (cfg_acc) begin
      col_d  = '0;
      pend_d = '0;
      ocol_d = '0;
      orow_d = '0;
    end else if (in_acc) begin
      if (!is_flush) begin
        col_d = (col_q == wm1_q) ? '0 : col_q + AW'(1);
        if (!emit0) begin
          pend_d = pend_q + PW'(1);
        end
      end else if (emit0) begin
        pend_d = pend_q - PW'(1);
      end
      if (emit0) begin
        if (ocol_q == wm1_q) begin
          ocol_d = '0;
          orow_d = (orow_q == hm1_q) ? '0 : orow_q + IMG_H_W'(1);
        end else begin
          ocol_d = ocol_q + AW'(1);
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wm1_q  <= AW'(RST_W_EFF - 1);
      hm1_q  <= IMG_H_W'(RESET_HEIGHT - 1);
      col_q  <= '0;
      pend_q <= '0;
      ocol_q <= '0;
      orow_q <= '0;
    end else begin
      wm1_q  <= wm1_d;
      hm1_q  <= hm1_d;
      col_q  <= col_d;
      pend_q <= pend_d;
      ocol_q <= ocol_d;
      orow_q <= orow_d;
    end
  end

  // ---------------- stage 1: line RAMs, bypass, window shift ----------------
  logic          s1_valid_q, s1_emit_q;
  logic          s1_flush_q, s1_filter_q, s1_last_q, s1_sel_mid_q;
  logic          s1_byp_up_q, s1_byp_mid_q;
  logic [AW-1:0] s1_col_q;
  pixel_t        s1_px_q, byp_up_px_q, byp_mid_px_q;
  logic          s1_wr;
  pixel_t        up_rdata, mid_rdata, up_rd, mid_rd;

  assign s1_wr = s1_valid_q && !s1_flush_q;

  // upper row store gets the displaced middle row word, middle gets the pixel
  sef_ram #(.WIDTH(PIX_W), .DEPTH(MAX_WIDTH)) u_ram_up (
    .clk_i   (clk_i),
    .we_i    (s1_wr),
    .waddr_i (s1_col_q),
    .wdata_i (mid_rd),
    .raddr_i (raddr_up),
    .rdata_o (up_rdata)
  );

  sef_ram #(.WIDTH(PIX_W), .DEPTH(MAX_WIDTH)) u_ram_mid (
    .clk_i   (clk_i),
    .we_i    (s1_wr),
    .waddr_i (s1_col_q),
    .wdata_i (s1_px_q),
    .raddr_i (raddr_mid),
    .rdata_o (mid_rdata)
  );

  // a read that hits the word written in the same cycle takes the new word
  assign up_rd  = s1_byp_up_q  ? byp_up_px_q  : up_rdata;
  assign mid_rd = s1_byp_mid_q ? byp_mid_px_q : mid_rdata;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s1_emit_q  <= 1'b0;
    end else begin
      s1_valid_q <= in_acc;
      s1_emit_q  <= in_acc && emit0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      s1_flush_q   <= is_flush;
      s1_filter_q  <= !is_flush && !border0;
      s1_last_q    <= last0;
      s1_sel_mid_q <= sel_mid0;
      s1_col_q     <= col_q;
      s1_px_q      <= px_in;
      s1_byp_up_q  <= s1_wr && (raddr_up == s1_col_q);
      s1_byp_mid_q <= s1_wr && (raddr_mid == s1_col_q);
      byp_up_px_q  <= mid_rd;
      byp_mid_px_q <= s1_px_q;
    end
  end

  // window: win[0] oldest column, win[2] newest
  column_t win [3];
  column_t new_col;

  assign new_col = '{top: up_rd, mid: mid_rd, bot: s1_px_q};

  for (genvar k = 0; k < 3; k++) begin : g_cell
    if (k == 2) begin : g_head
      sef_col_cell u_cell (
        .clk_i  (clk_i),
        .rst_ni (rst_ni),
        .en_i   (s1_wr),
        .col_i  (new_col),
        .col_o  (win[k])
      );
    end else begin : g_body
      sef_col_cell u_cell (
        .clk_i  (clk_i),
        .rst_ni (rst_ni),
        .en_i   (s1_wr),
        .col_i  (win[k+1]),
        .col_o  (win[k])
      );
    end
  end

  // ---------------- stage 2: Sobel and result select ----------------
  logic   s2_emit_q, s2_flush_q, s2_filter_q, s2_last_q;
  pixel_t s2_px_q, sobel_px, res_px;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_emit_q <= 1'b0;
    end else begin
      s2_emit_q <= s1_emit_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_emit_q) begin
      s2_flush_q  <= s1_flush_q;
      s2_filter_q <= s1_filter_q;
      s2_last_q   <= s1_last_q;
      s2_px_q     <= s1_sel_mid_q ? mid_rd : up_rd;
    end
  end

  for (genvar ch = 0; ch < NUM_CH; ch++) begin : g_ch
    sef_sobel_ch u_sobel (
      .t_i   ({win[2].top[ch], win[1].top[ch], win[0].top[ch]}),
      .m0_i  (win[0].mid[ch]),
      .m2_i  (win[2].mid[ch]),
      .b_i   ({win[2].bot[ch], win[1].bot[ch], win[0].bot[ch]}),
      .res_o (sobel_px[ch])
    );
  end

  always_comb begin
    if (s2_filter_q) begin
      res_px = sobel_px;
    end else if (s2_flush_q) begin
      res_px = s2_px_q;
    end else begin
      res_px = win[1].mid;
    end
  end

  // ---------------- result queue ----------------
  result_t               fifo_q [FIFO_DEPTH];
  logic [FIFO_PTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [FIFO_PTR_W:0]   cnt_q, cnt_d, in_flight;
  logic                  push, pop;
  result_t               head;

  assign push      = s2_emit_q;
  assign pop       = pix_o.valid && pix_o.ready;
  assign head      = fifo_q[rd_ptr_q];
  assign in_flight = cnt_q + (FIFO_PTR_W + 1)'(s1_emit_q)
                           + (FIFO_PTR_W + 1)'(s2_emit_q);

  // room for this transaction's result on top of everything in flight
  assign pix_i.ready = in_flight < (FIFO_PTR_W + 1)'(FIFO_DEPTH);

  always_comb begin
    cnt_d = cnt_q;
    if (push && !pop) begin
      cnt_d = cnt_q + (FIFO_PTR_W + 1)'(1);
    end else if (pop && !push) begin
      cnt_d = cnt_q - (FIFO_PTR_W + 1)'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push) begin
        wr_ptr_q <= wr_ptr_q + FIFO_PTR_W'(1);
      end
      if (pop) begin
        rd_ptr_q <= rd_ptr_q + FIFO_PTR_W'(1);
      end
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      fifo_q[wr_ptr_q] <= '{px: res_px, last: s2_last_q};
    end
  end

  assign pix_o.valid      = (cnt_q != '0);
  assign pix_o.red_out    = head.px[2];
  assign pix_o.green_out  = head.px[1];
  assign pix_o.blue_out   = head.px[0];
  assign pix_o.frame_last = head.last;

endmodule

`default_nettype wire

FILE: src/sef_checker.sv
`default_nettype none

module sef_checker (
  input logic                     clk_i,
  input logic                     rst_ni,
  input logic                     in_valid_i,
  input logic                     in_ready_i,
  input logic                     in_flush_i,
  input logic                     out_valid_i,
  input logic                     out_ready_i,
  input logic [sef_pkg::CH_W-1:0] out_red_i,
  input logic [sef_pkg::CH_W-1:0] out_green_i,
  input logic [sef_pkg::CH_W-1:0] out_blue_i,
  input logic                     out_last_i
);
  import sef_pkg::*;

  logic        in_pix_acc, out_acc;
  logic [31:0] tokens_q;   // pixels taken minus results delivered

  assign in_pix_acc = in_valid_i && in_ready_i && !in_flush_i;
  assign out_acc    = out_valid_i && out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tokens_q <= '0;
    end else begin
      tokens_q <= tokens_q + 32'(in_pix_acc) - 32'(out_acc);
    end
  end

  // every result stands for a pixel that came in earlier
  a_no_invented_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_acc |-> tokens_q != '0)
    else $error("result without a pending pixel");

  // input backpressure only comes from queued results
  a_ready_needs_backlog: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_i |-> out_valid_i)
    else $error("input stalled with nothing waiting at the output");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_red_i) &&
      $stable(out_green_i) && $stable(out_blue_i) && $stable(out_last_i))
    else $error("stalled result changed");

endmodule

bind sobel_edge_filter_3x3 sef_checker u_sef_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (pix_i.valid),
  .in_ready_i  (pix_i.ready),
  .in_flush_i  (pix_i.flush),
  .out_valid_i (pix_o.valid),
  .out_ready_i (pix_o.ready),
  .out_red_i   (pix_o.red_out),
  .out_green_i (pix_o.green_out),
  .out_blue_i  (pix_o.blue_out),
  .out_last_i  (pix_o.frame_last)
);

`default_nettype wire
